>>> hdl/impq_pkg.sv
// shared types, constants and ordering function for the indexed max priority queue
// no dependencies
`default_nettype none

package impq_pkg;

   localparam int CAPACITY      = 64;
   localparam int KEY_BITS      = 6;
   localparam int PRIORITY_BITS = 16;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
   localparam int GROUP_SIZE    = 8;
   localparam int NUM_GROUPS    = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   // operation codes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_ERASE  = 2'd2;
   localparam logic [1:0] MODE_PROBE  = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // cell commands
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_SCAN   = 2'd1;
   localparam logic [1:0] CELL_REMOVE = 2'd2;
   localparam logic [1:0] CELL_INSERT = 2'd3;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [KEY_BITS-1:0]      key;
   } entry_type;

   typedef struct packed {
      logic [1:0]               mode;
      logic [KEY_BITS-1:0]      entry_key;
      logic [PRIORITY_BITS-1:0] entry_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic                     was_present;
      logic                     removed_valid;
      logic [PRIORITY_BITS-1:0] removed_priority;
      logic [KEY_BITS-1:0]      removed_key;
      logic                     top_valid;
      logic [PRIORITY_BITS-1:0] top_priority;
      logic [KEY_BITS-1:0]      top_key;
      logic [COUNT_BITS-1:0]    entry_count;
   } rsp_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic [1:0]          cmd;
      logic [KEY_BITS-1:0] key;
      entry_type           operand;
   } cell_ctl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic      valid;
      entry_type entry;
      logic      goes_before;
   } cell_link_type;

   function automatic logic better(input entry_type a, input entry_type b);
      better = (a.prio > b.prio) || ((a.prio == b.prio) && (a.key > b.key));
   endfunction

endpackage

`default_nettype wire

>>> hdl/impq_cell.sv
// one slot of the sorted cell row: holds an entry, shifts on insert and remove
// depends on impq_pkg
`default_nettype none

module impq_cell
   import impq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctl_type  ctl,
   input  wire cell_link_type from_left,
   input  wire cell_link_type from_right,
   output      cell_link_type link,
   output      logic          hit,
   output      entry_type     hit_entry
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      hit_ff, hit_in;
   entry_type hit_entry_ff, hit_entry_in;
   logic      goes_before;

   assign goes_before = !valid_ff || better(ctl.operand, entry_ff);

   always_comb begin
      valid_in     = valid_ff;
      entry_in     = entry_ff;
      hit_in       = hit_ff;
      hit_entry_in = hit_entry_ff;
      case (ctl.cmd)
         CELL_SCAN: begin
            hit_in       = valid_ff && (entry_ff.key == ctl.key);
            hit_entry_in = hit_in ? entry_ff : '0;
         end
         CELL_REMOVE: begin
            if (!valid_ff || !better(entry_ff, ctl.operand)) begin
               valid_in = from_right.valid;
               entry_in = from_right.entry;
            end
         end
         CELL_INSERT: begin
            if (from_left.goes_before) begin
               valid_in = from_left.valid;
               entry_in = from_left.entry;
            end else if (goes_before) begin
               valid_in = 1'b1;
               entry_in = ctl.operand;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
      entry_ff     <= entry_in;
      hit_entry_ff <= hit_entry_in;
   end

   assign link.valid       = valid_ff;
   assign link.entry       = entry_ff;
   assign link.goes_before = goes_before;
   assign hit              = hit_ff;
   assign hit_entry        = hit_entry_ff;

endmodule

`default_nettype wire

>>> hdl/indexed_max_priority_queue.sv
// indexed max priority queue: sequencer, key match tree and the sorted cell row
// depends on impq_pkg and impq_cell
// a request passes the three-stage key match tree, then one shift of the cell row per remove
//   and per insert, and then the result load, which waits while the result channel stalls
// one item at a time: a new request is taken only in idle, after the last result is loaded (update takes the longest)
// reset: synchronous, clears every cell and the entry count; no clearing pass
`default_nettype none

module indexed_max_priority_queue
   import impq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_GROUP  = 3'd2;
   localparam logic [2:0] ST_REDUCE = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_REMOVE = 3'd5;
   localparam logic [2:0] ST_INSERT = 3'd6;
   localparam logic [2:0] ST_RESP   = 3'd7;

   logic [2:0]            state_ff, state_in;
   req_type               req_ff, req_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   entry_type             ref_ff, ref_in;
   logic [1:0]            status_ff, status_in;
   logic                  was_ff, was_in;
   logic                  rvalid_ff, rvalid_in;
   entry_type             rentry_ff, rentry_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [NUM_GROUPS-1:0] grp_hit_ff, grp_hit_in;
   entry_type             grp_entry_ff [NUM_GROUPS];
   entry_type             grp_entry_in [NUM_GROUPS];
   logic                  found_ff, found_in;
   entry_type             found_entry_ff, found_entry_in;

   cell_ctl_type          ctl;
   cell_link_type         link [CAPACITY];
   logic [CAPACITY-1:0]   hit;
   entry_type             hit_entry [CAPACITY];
   entry_type             new_entry;
   logic                  req_xfer;
   logic                  rsp_free;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign new_entry = '{prio: req_ff.entry_priority, key: req_ff.entry_key};

   always_comb begin
      ctl.key     = req_ff.entry_key;
      ctl.operand = (state_ff == ST_INSERT) ? new_entry : ref_ff;
      case (state_ff)
         ST_SCAN:   ctl.cmd = CELL_SCAN;
         ST_REMOVE: ctl.cmd = CELL_REMOVE;
         ST_INSERT: ctl.cmd = CELL_INSERT;
         default:   ctl.cmd = CELL_HOLD;
      endcase
   end

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type left_link, right_link;
      if (i == 0) begin : g_first
         assign left_link = '0;
      end else begin : g_mid_left
         assign left_link = link[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_link = '0;
      end else begin : g_mid_right
         assign right_link = link[i+1];
      end
      impq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .from_left  (left_link),
         .from_right (right_link),
         .link       (link[i]),
         .hit        (hit[i]),
         .hit_entry  (hit_entry[i])
      );
   end

   // key match tree, first level
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_hit_in[g]   = 1'b0;
         grp_entry_in[g] = '0;
         for (int m = 0; m < GROUP_SIZE; m++) begin
            if (g * GROUP_SIZE + m < CAPACITY) begin
               grp_hit_in[g]   = grp_hit_in[g] | hit[g * GROUP_SIZE + m];
               grp_entry_in[g] = grp_entry_in[g] | hit_entry[g * GROUP_SIZE + m];
            end
         end
      end
   end

   // key match tree, second level
   always_comb begin
      found_in       = |grp_hit_ff;
      found_entry_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         found_entry_in = found_entry_in | grp_entry_ff[g];
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      ref_in       = ref_ff;
      status_in    = status_ff;
      was_in       = was_ff;
      rvalid_in    = rvalid_ff;
      rentry_in    = rentry_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_in   = req_data;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN:   state_in = ST_GROUP;
         ST_GROUP:  state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_DECIDE;
         ST_DECIDE: begin
            status_in = STATUS_OK;
            was_in    = found_ff;
            rvalid_in = 1'b0;
            rentry_in = '0;
            ref_in    = found_entry_ff;
            state_in  = ST_RESP;
            case (req_ff.mode)
               MODE_INSERT: begin
                  if (found_ff) begin
                     state_in = ST_REMOVE;
                  end else if (count_ff == COUNT_BITS'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     count_in = count_ff + 1'b1;
                     state_in = ST_INSERT;
                  end
               end
               MODE_POP: begin
                  was_in = 1'b0;
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     rvalid_in = 1'b1;
                     rentry_in = link[0].entry;
                     ref_in    = link[0].entry;
                     count_in  = count_ff - 1'b1;
                     state_in  = ST_REMOVE;
                  end
               end
               MODE_ERASE: begin
                  if (!found_ff) begin
                     status_in = STATUS_NOT_FOUND;
                  end else begin
                     rvalid_in = 1'b1;
                     rentry_in = found_entry_ff;
                     count_in  = count_ff - 1'b1;
                     state_in  = ST_REMOVE;
                  end
               end
               default: begin
                  if (!found_ff) begin
                     status_in = STATUS_NOT_FOUND;
                  end
               end
            endcase
         end
         ST_REMOVE: begin
            // update takes the old entry out, then puts the new one in
            state_in = (req_ff.mode == MODE_INSERT) ? ST_INSERT : ST_RESP;
         end
         ST_INSERT: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in.status           = status_ff;
               rsp_in.was_present      = was_ff;
               rsp_in.removed_valid    = rvalid_ff;
               rsp_in.removed_priority = rentry_ff.prio;
               rsp_in.removed_key      = rentry_ff.key;
               rsp_in.top_valid        = link[0].valid;
               rsp_in.top_priority     = link[0].valid ? link[0].entry.prio : '0;
               rsp_in.top_key          = link[0].valid ? link[0].entry.key : '0;
               rsp_in.entry_count      = count_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         grp_hit_ff   <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         grp_hit_ff   <= grp_hit_in;
         found_ff     <= found_in;
      end
      req_ff         <= req_in;
      ref_ff         <= ref_in;
      status_ff      <= status_in;
      was_ff         <= was_in;
      rvalid_ff      <= rvalid_in;
      rentry_ff      <= rentry_in;
      rsp_ff         <= rsp_in;
      grp_entry_ff   <= grp_entry_in;
      found_entry_ff <= found_entry_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for indexed_max_priority_queue: directed and random operations
// with random idling on both channels, checked against a per-key priority table
// depends on impq_pkg and the queue rtl

module tb;
   import impq_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_ITEMS    = 475;
   localparam int HOLD_CYCLES    = 400;

   typedef struct {
      req_type op;
      bit      wait_drain;
      int      phase;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_type pending_ops[$];
   rsp_type     awaited_results[$];

   // queue contents as seen by the predictor
   logic                     key_held[1 << KEY_BITS];
   logic [PRIORITY_BITS-1:0] key_prio[1 << KEY_BITS];
   int                       held_count = 0;

   int tx_idle[3] = '{14, 46, 0};
   int rx_idle[3] = '{46, 14, 0};
   int cur_phase = 0;
   int gen_phase = 0;
   bit gen_wait = 1'b0;
   int gen_items = 0;

   int errors = 0;
   int ops_sent = 0;
   int results_seen = 0;
   int fast_sent = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int idle_cycles = 0;
   int mode_seen[4] = '{0, 0, 0, 0};
   int full_hits = 0;
   int empty_pops = 0;
   int missing_keys = 0;

   indexed_max_priority_queue u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // best held key: highest priority, larger key on a tie; -1 when empty
   function automatic int best_key();
      int bk;
      bk = -1;
      for (int k = 0; k < (1 << KEY_BITS); k++) begin
         if (key_held[k] && (bk < 0 || key_prio[k] >= key_prio[bk]))
            bk = k;
      end
      return bk;
   endfunction

   function automatic rsp_type queue_apply(input req_type op);
      rsp_type r;
      logic    was_held;
      int      bk;
      r = '0;
      was_held = key_held[op.entry_key];
      mode_seen[op.mode]++;
      case (op.mode)
         MODE_INSERT: begin
            r.was_present = was_held;
            if (was_held) begin
               key_prio[op.entry_key] = op.entry_priority;
            end else if (held_count >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               key_held[op.entry_key] = 1'b1;
               key_prio[op.entry_key] = op.entry_priority;
               held_count++;
            end
         end
         MODE_POP: begin
            bk = best_key();
            if (bk < 0) begin
               r.status = STATUS_EMPTY;
               empty_pops++;
            end else begin
               r.removed_valid    = 1'b1;
               r.removed_priority = key_prio[bk];
               r.removed_key      = bk[KEY_BITS-1:0];
               key_held[bk]       = 1'b0;
               held_count--;
            end
         end
         MODE_ERASE: begin
            r.was_present = was_held;
            if (!was_held) begin
               r.status = STATUS_NOT_FOUND;
               missing_keys++;
            end else begin
               r.removed_valid          = 1'b1;
               r.removed_priority       = key_prio[op.entry_key];
               r.removed_key            = op.entry_key;
               key_held[op.entry_key]   = 1'b0;
               held_count--;
            end
         end
         MODE_PROBE: begin
            r.was_present = was_held;
            r.status      = was_held ? STATUS_OK : STATUS_NOT_FOUND;
         end
      endcase
      bk = best_key();
      if (bk >= 0) begin
         r.top_valid    = 1'b1;
         r.top_priority = key_prio[bk];
         r.top_key      = bk[KEY_BITS-1:0];
      end
      r.entry_count = COUNT_BITS'(held_count);
      if (held_count == CAPACITY)
         full_hits++;
      return r;
   endfunction

   task automatic field_error(input string name, input int exp_val, input int got_val);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_val, got_val);
   endtask

   task automatic compare_result(input rsp_type exp_r, input rsp_type got);
      if (got.status !== exp_r.status)
         field_error("status", exp_r.status, got.status);
      if (got.was_present !== exp_r.was_present)
         field_error("was_present", exp_r.was_present, got.was_present);
      if (got.removed_valid !== exp_r.removed_valid)
         field_error("removed_valid", exp_r.removed_valid, got.removed_valid);
      if (got.removed_priority !== exp_r.removed_priority)
         field_error("removed_priority", exp_r.removed_priority, got.removed_priority);
      if (got.removed_key !== exp_r.removed_key)
         field_error("removed_key", exp_r.removed_key, got.removed_key);
      if (got.top_valid !== exp_r.top_valid)
         field_error("top_valid", exp_r.top_valid, got.top_valid);
      if (got.top_priority !== exp_r.top_priority)
         field_error("top_priority", exp_r.top_priority, got.top_priority);
      if (got.top_key !== exp_r.top_key)
         field_error("top_key", exp_r.top_key, got.top_key);
      if (got.entry_count !== exp_r.entry_count)
         field_error("entry_count", exp_r.entry_count, got.entry_count);
   endtask

   task automatic add_op(input logic [1:0] mode, input int key, input int prio);
      pending_type p;
      p.op.mode           = mode;
      p.op.entry_key      = key[KEY_BITS-1:0];
      p.op.entry_priority = prio[PRIORITY_BITS-1:0];
      p.wait_drain        = gen_wait;
      p.phase             = gen_phase;
      gen_wait = 1'b0;
      gen_items++;
      pending_ops.push_back(p);
   endtask

   function automatic int rand_prio();
      case ($urandom_range(9))
         0:       return 0;
         1:       return (1 << PRIORITY_BITS) - 1;
         2, 3:    return $urandom_range(7);
         default: return $urandom_range((1 << PRIORITY_BITS) - 1);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin : drive_ops
      logic go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(queue_apply(req_data));
            if (pending_ops[0].phase == 2)
               fast_sent++;
            void'(pending_ops.pop_front());
            ops_sent++;
         end
         if (req_valid && req_stall) begin
            go = 1'b1;
         end else begin
            go = 1'b0;
            if (pending_ops.size() > 0) begin
               cur_phase = pending_ops[0].phase;
               if (!(pending_ops[0].wait_drain && awaited_results.size() != 0)
                   && $urandom_range(99) >= tx_idle[cur_phase])
                  go = 1'b1;
            end
            if (go)
               req_data <= pending_ops[0].op;
         end
         req_valid <= go;
      end
   end

   // monitor and result-side stall
   always @(posedge clock) begin : watch_results
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               errors++;
               $display("%0t: result with nothing expected, got %p", $time, rsp_data);
            end else begin
               compare_result(awaited_results.pop_front(), rsp_data);
            end
         end
         if (!hold_done && fast_sent >= 40) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle[cur_phase]);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("indexed_max_priority_queue: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int order[1 << KEY_BITS];
      int j;
      int t;
      int r;
      int n;
      for (int k = 0; k < (1 << KEY_BITS); k++) begin
         key_held[k] = 1'b0;
         key_prio[k] = '0;
      end

      // directed: empty cases, extremes, ties, updates, erase of top and bottom
      add_op(MODE_POP, 0, 0);
      add_op(MODE_ERASE, 5, 0);
      add_op(MODE_PROBE, 63, 16'hffff);
      add_op(MODE_INSERT, 0, 0);
      add_op(MODE_INSERT, 63, 16'hffff);
      add_op(MODE_INSERT, 31, 16'hffff);
      add_op(MODE_INSERT, 62, 0);
      add_op(MODE_PROBE, 63, 16'h1234);
      add_op(MODE_INSERT, 0, 16'hffff);
      add_op(MODE_INSERT, 63, 1);
      add_op(MODE_INSERT, 31, 16'hffff);
      add_op(MODE_ERASE, 31, 16'hffff);
      add_op(MODE_ERASE, 62, 0);
      add_op(MODE_POP, 0, 0);
      add_op(MODE_POP, 63, 16'hffff);
      add_op(MODE_POP, 0, 0);
      add_op(MODE_INSERT, 21, 16'haaaa);
      add_op(MODE_INSERT, 42, 16'h5555);
      add_op(MODE_ERASE, 42, 16'hffff);
      add_op(MODE_PROBE, 42, 16'h8001);
      add_op(MODE_POP, 63, 16'h7fff);

      // random part in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         gen_phase = ph;
         gen_wait  = 1'b1;
         gen_items = 0;
         while (gen_items < PHASE_ITEMS) begin
            r = $urandom_range(9);
            if (r < 2) begin
               // fill every key in random order, then a few updates
               for (int k = 0; k < (1 << KEY_BITS); k++)
                  order[k] = k;
               for (int k = (1 << KEY_BITS) - 1; k > 0; k--) begin
                  j = $urandom_range(k);
                  t = order[k];
                  order[k] = order[j];
                  order[j] = t;
               end
               for (int k = 0; k < (1 << KEY_BITS); k++)
                  add_op(MODE_INSERT, order[k], rand_prio());
               n = $urandom_range(1, 6);
               for (int k = 0; k < n; k++)
                  add_op(MODE_INSERT, $urandom_range(63), rand_prio());
            end else if (r == 2) begin
               n = $urandom_range(10, 70);
               for (int k = 0; k < n; k++)
                  add_op(MODE_POP, $urandom_range(63), $urandom_range(16'hffff));
            end else begin
               for (int k = 0; k < 40; k++) begin
                  t = $urandom_range(99);
                  if (t < 40)
                     add_op(MODE_INSERT, $urandom_range(63), rand_prio());
                  else if (t < 65)
                     add_op(MODE_POP, $urandom_range(63), $urandom_range(16'hffff));
                  else if (t < 85)
                     add_op(MODE_ERASE, $urandom_range(63), $urandom_range(16'hffff));
                  else
                     add_op(MODE_PROBE, $urandom_range(63), $urandom_range(16'hffff));
               end
            end
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || awaited_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d operations sent (%0d insert/update, %0d pop, %0d erase, %0d probe), %0d results",
               ops_sent, mode_seen[MODE_INSERT], mode_seen[MODE_POP], mode_seen[MODE_ERASE],
               mode_seen[MODE_PROBE], results_seen);
      $display("queue full of keys after %0d operations, %0d pops on empty, %0d lookups of absent keys",
               full_hits, empty_pops, missing_keys);
      if (errors == 0) begin
         $display("indexed_max_priority_queue: match");
      end else begin
         $display("%0d field errors", errors);
         $display("indexed_max_priority_queue: mismatch");
      end
      $finish;
   end

endmodule
